// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the UTF-8 stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define UTF8D_ASSERT(label, clk_sig, rst_sig, prop) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) \
        else $error("utf8d assertion failed");

// Implication checked at every clock edge outside reset.
`define UTF8D_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("utf8d implication failed");

`else

`define UTF8D_ASSERT(label, clk_sig, rst_sig, prop)
`define UTF8D_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons)

`endif

`endif

// ----- rtl/utf8d_pkg.sv -----
// Types and constants of the UTF-8 stream decoder.
package utf8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 31;
    localparam int COUNT_W = 3;
    localparam int CONT_W  = 6;

    localparam logic [BYTE_W-1:0] TOP_BIT   = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'h3F;

    // Count of leading ones at or above this value marks the bad leads 0xFE and 0xFF.
    localparam logic [COUNT_W-1:0] BAD_ONES  = 3'd7;
    localparam logic [COUNT_W-1:0] ONE_BYTE  = 3'd1;

    typedef struct packed {
        logic [CP_W-1:0]    acc;
        logic [COUNT_W-1:0] remaining;
        logic [COUNT_W-1:0] seq_len;
    } utf8d_state_t;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        logic               bad_lead;
    } utf8d_result_t;

endpackage

// ----- rtl/utf8d_byte_if.sv -----
// Handshake channel that carries raw stream bytes.
interface utf8d_byte_if
    import utf8d_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/utf8d_cp_if.sv -----
// Handshake channel that carries decoded code points.
interface utf8d_cp_if
    import utf8d_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [CP_W-1:0]    code_point;
    logic [COUNT_W-1:0] byte_count;
    logic               bad_lead;

    modport source (output valid, output code_point, output byte_count, output bad_lead,
                    input ready);
    modport sink   (input valid, input code_point, input byte_count, input bad_lead,
                    output ready);
endinterface

// ----- rtl/utf8d_step.sv -----
// Combinational decode of one byte against the current sequence state.
module utf8d_step
    import utf8d_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  utf8d_state_t      state,
    output utf8d_state_t      state_next,
    output logic              emit,
    output utf8d_result_t     result
);

    logic [COUNT_W-1:0] ones;
    logic [6:0]         lead_mask;
    logic [CP_W-1:0]    acc_shift;

    always_comb
    begin
        unique casez (in_byte)
            8'b0???????: ones = 3'd0;
            8'b10??????: ones = 3'd1;
            8'b110?????: ones = 3'd2;
            8'b1110????: ones = 3'd3;
            8'b11110???: ones = 3'd4;
            8'b111110??: ones = 3'd5;
            8'b1111110?: ones = 3'd6;
            default:     ones = BAD_ONES;
        endcase
    end

    assign lead_mask = 7'h7F >> ones;
    assign acc_shift = {state.acc[CP_W-CONT_W-1:0], in_byte[CONT_W-1:0] & CONT_MASK[CONT_W-1:0]};

    always_comb
    begin
        state_next        = state;
        emit              = 1'b0;
        result.code_point = {{(CP_W-BYTE_W){1'b0}}, in_byte};
        result.byte_count = ONE_BYTE;
        result.bad_lead   = 1'b0;

        if (state.remaining != '0)
        begin
            // Continuation bytes are taken as they come; only the low six bits count.
            state_next.acc       = acc_shift;
            state_next.remaining = state.remaining - 3'd1;
            if (state.remaining == 3'd1)
            begin
                emit               = 1'b1;
                result.code_point  = acc_shift;
                result.byte_count  = state.seq_len;
                state_next.seq_len = '0;
            end
        end
        else if (ones == BAD_ONES)
        begin
            emit            = 1'b1;
            result.bad_lead = 1'b1;
        end
        else if (ones <= 3'd1)
        begin
            emit = 1'b1;
        end
        else
        begin
            state_next.acc       = {{(CP_W-7){1'b0}}, in_byte[6:0] & lead_mask};
            state_next.seq_len   = ones;
            state_next.remaining = ones - 3'd1;
        end
    end

endmodule

// ----- rtl/utf8_stream_decoder_top.sv -----
// Top level of the byte-serial UTF-8 decoder for sequences of up to six bytes.
//
//  channel    | role   | payload
//  -----------+--------+-------------------------------------------
//  byte_ch    | sink   | in_byte
//  cp_ch      | source | code_point, byte_count, bad_lead
//
// One item is accepted per cycle while cp_ch does not stall; a byte is decoded from the
// input register, and its result is registered in the output register that drives cp_ch.valid.
// The sequence state updates once per byte in a single shift-and-or step.
// Reset drops any sequence in progress and empties both registers.
// When cp_ch stalls, the input register holds its byte and byte_ch.ready falls once it holds one.
`include "assert_macros.svh"

module utf8_stream_decoder_top
    import utf8d_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    utf8d_byte_if.sink byte_ch,
    utf8d_cp_if.source cp_ch
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    utf8d_state_t  state_reg;
    utf8d_state_t  state_next;
    logic          emit;
    utf8d_result_t result;

    logic          out_valid_reg;
    utf8d_result_t out_reg;

    logic out_free;
    logic advance;

    logic rem_idle;
    logic seq_idle;
    logic out_bad;

    assign out_free      = !out_valid_reg || cp_ch.ready;
    assign advance       = in_valid_reg && out_free;
    assign byte_ch.ready = !in_valid_reg || advance;

    utf8d_step u_step (
        .in_byte    (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_ch.ready)
        begin
            in_valid_reg <= byte_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg <= result;
        end
    end

    assign cp_ch.valid      = out_valid_reg;
    assign cp_ch.code_point = out_reg.code_point;
    assign cp_ch.byte_count = out_reg.byte_count;
    assign cp_ch.bad_lead   = out_reg.bad_lead;

    assign rem_idle = (state_reg.remaining == '0);
    assign seq_idle = (state_reg.seq_len == '0);
    assign out_bad  = cp_ch.valid && cp_ch.bad_lead;

    `UTF8D_ASSERT(a_seq_tracks_remaining, clk, rst_n, rem_idle == seq_idle)
    `UTF8D_ASSERT(a_remaining_range, clk, rst_n, state_reg.remaining <= 3'd5)
    `UTF8D_ASSERT_IMPL(a_bad_lead_single, clk, rst_n, out_bad, cp_ch.byte_count == ONE_BYTE)

endmodule

// ----- tb/utf8d_checker.sv -----
// Checker for the UTF-8 stream decoder: predicts code points from accepted bytes and compares.
`timescale 1ns / 100ps

module utf8d_checker
    import utf8d_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    utf8d_byte_if byte_ch,
    utf8d_cp_if   cp_ch,
    output int    fail_count,
    output int    pending
);

    utf8d_state_t  dec;
    utf8d_result_t expected_cps [$];

    function automatic int leading_ones(input logic [BYTE_W-1:0] b);
        int n;
        n = 0;
        while (n < BYTE_W && b[BYTE_W-1-n])
            n++;
        return n;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: code point mismatch on %s: got 0x%0h, want 0x%0h",
                 $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        int            ones;
        utf8d_result_t cp;
        ones = leading_ones(b);
        if (dec.remaining != '0)
        begin
            // Any byte continues a sequence; only its low six bits count.
            dec.acc       = {dec.acc[CP_W-1-CONT_W:0], b[CONT_W-1:0]};
            dec.remaining = dec.remaining - 3'd1;
            if (dec.remaining == '0)
            begin
                cp.code_point = dec.acc;
                cp.byte_count = dec.seq_len;
                cp.bad_lead   = 1'b0;
                dec.seq_len   = '0;
                expected_cps.push_back(cp);
            end
        end
        else if (ones >= BAD_ONES || ones <= 1)
        begin
            cp.code_point = CP_W'(b);
            cp.byte_count = ONE_BYTE;
            cp.bad_lead   = (ones >= BAD_ONES);
            expected_cps.push_back(cp);
        end
        else
        begin
            // A lead of n bytes keeps its low 7 - n bits.
            dec.acc       = CP_W'(b & (8'hFF >> (ones + 1)));
            dec.seq_len   = COUNT_W'(ones);
            dec.remaining = COUNT_W'(ones - 1);
        end
    endtask

    task automatic check_cp();
        utf8d_result_t want;
        if (expected_cps.size() == 0)
        begin
            report_mismatch("unexpected item", 32'(cp_ch.code_point), 32'h0);
            return;
        end
        want = expected_cps.pop_front();
        if (cp_ch.code_point !== want.code_point)
            report_mismatch("code_point", 32'(cp_ch.code_point), 32'(want.code_point));
        if (cp_ch.byte_count !== want.byte_count)
            report_mismatch("byte_count", 32'(cp_ch.byte_count), 32'(want.byte_count));
        if (cp_ch.bad_lead !== want.bad_lead)
            report_mismatch("bad_lead", 32'(cp_ch.bad_lead), 32'(want.bad_lead));
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            dec = '0;
            expected_cps.delete();
            fail_count = 0;
        end
        else
        begin
            if (byte_ch.valid && byte_ch.ready)
                predict_byte(byte_ch.in_byte);
            if (cp_ch.valid && cp_ch.ready)
                check_cp();
        end
        pending = expected_cps.size();
    end

endmodule

// ----- tb/tb_top.sv -----
// Top of the UTF-8 stream decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top
    import utf8d_pkg::*;
();

    localparam int HOLD_CYCLES = 64;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 540;

    // Plain bytes, stray continuation, bad leads, then sequences of two to six
    // bytes; the two-byte one takes 0xFF as a continuation, the three-byte one
    // takes bytes that carry no continuation prefix, the six-byte one is the
    // largest code point.
    localparam logic [BYTE_W-1:0] DIRECTED [25] = '{
        8'h00, 8'h7F, 8'h80, 8'hFE, 8'hFF,
        8'hC3, 8'hFF,
        8'hE2, 8'h00, 8'h41,
        8'hF0, 8'h9F, 8'h98, 8'h80,
        8'hF8, 8'h88, 8'h80, 8'h80, 8'h80,
        8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF
    };

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   pending;
    int   quiet_cycles;

    utf8d_byte_if byte_ch ();
    utf8d_cp_if   cp_ch ();

    always #4 clk = ~clk;

    utf8_stream_decoder_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cp_ch   (cp_ch)
    );

    utf8d_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .cp_ch      (cp_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random stalls, and a long hold-off when asked for one.
    initial
    begin
        int hold_left;
        hold_left = 0;
        cp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
                hold_left = HOLD_CYCLES;
            if (hold_left != 0)
            begin
                hold_left--;
                cp_ch.ready <= 1'b0;
            end
            else
                cp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_ch.valid && byte_ch.ready) || (cp_ch.valid && cp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!byte_ch.ready);
    endtask

    task automatic wait_all_results();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed sequences with random payload, in which some continuation
    // bytes are random bytes; the rest is single random bytes, bad leads and
    // stray continuations.
    task automatic send_stream(input int count);
        int                sent;
        int                len;
        logic [BYTE_W-1:0] b;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 80)
            begin
                len = $urandom_range(6, 1);
                if (len == 1)
                    b = {1'b0, 7'($urandom)};
                else
                    b = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
                send_byte(b);
                for (int k = 1; k < len; k++)
                begin
                    if ($urandom_range(9) == 0)
                        b = 8'($urandom);
                    else
                        b = {2'b10, 6'($urandom)};
                    send_byte(b);
                end
                sent += len;
            end
            else
            begin
                case ($urandom_range(3))
                    0:       b = 8'hFE;
                    1:       b = 8'hFF;
                    2:       b = {2'b10, 6'($urandom)};
                    default: b = 8'($urandom);
                endcase
                send_byte(b);
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_req <= 1'b0;
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        byte_ch.valid <= 1'b0;
        byte_ch.in_byte <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
            send_byte(DIRECTED[i]);
        wait_all_results();

        send_idle_pct <= 15;
        recv_idle_pct <= 70;
        send_stream(PHASE_ITEMS);

        // The receiver holds off while bytes keep coming, so the block fills.
        send_idle_pct <= 0;
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        for (int i = 0; i < 40; i++)
            send_byte({1'b0, 7'($urandom)});
        wait_all_results();

        send_idle_pct <= 70;
        recv_idle_pct <= 15;
        @(posedge clk);
        send_stream(PHASE_ITEMS);

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        send_stream(PHASE_ITEMS);

        wait_all_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
